// File: rtl/i2d_pkg.sv
// i2d_pkg: shared types and constants for the 128-bit signed decimal converter.
// No dependencies; used by i2d_cell and int128_to_signed_decimal.
`default_nettype none

package i2d_pkg;

  localparam int VALUE_BITS  = 128;
  localparam int EFF_BITS    = (VALUE_BITS > 128) ? 128 : VALUE_BITS;
  localparam int BIT_CNT_W   = (EFF_BITS > 1) ? $clog2(EFF_BITS) : 1;
  localparam int DIGIT_SLOTS = 40;
  localparam int DIG_CNT_W   = $clog2(DIGIT_SLOTS + 1);

  localparam logic [5:0] CHAR_ZERO  = 6'd48;
  localparam logic [5:0] CHAR_MINUS = 6'd45;

  typedef struct packed {
    logic [63:0] value_high;
    logic [63:0] value_low;
  } in_item_t;

  typedef struct packed {
    logic [5:0] text_char;
    logic       is_last;
  } out_item_t;

  typedef struct packed {
    logic clear;   // zero the digit
    logic dabble;  // double and add carry from lower neighbor
    logic shift;   // take lower neighbor's digit
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/i2d_cell.sv
// i2d_cell: one BCD digit of the converter chain.
// Depends on i2d_pkg for the control struct.
`default_nettype none

module i2d_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  i2d_pkg::cell_ctrl_t   ctrl_i,
  input  logic                  carry_i,
  input  logic [3:0]            digit_i,
  output logic                  carry_o,
  output logic [3:0]            digit_o
);

  logic [3:0] digit_q, digit_d;
  logic [4:0] dbl;

  assign dbl     = {digit_q, carry_i};
  assign carry_o = (digit_q >= 4'd5);
  assign digit_o = digit_q;

  always_comb begin
    if (ctrl_i.clear) begin
      digit_d = 4'd0;
    end else if (ctrl_i.dabble) begin
      digit_d = carry_o ? 4'(dbl - 5'd10) : dbl[3:0];
    end else if (ctrl_i.shift) begin
      digit_d = digit_i;
    end else begin
      digit_d = digit_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= 4'd0;
    end else begin
      digit_q <= digit_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/int128_to_signed_decimal.sv
// int128_to_signed_decimal: 128-bit two's-complement to signed ASCII decimal.
// Depends on i2d_pkg and i2d_cell (a row of 40 BCD digit cells).
//
// Usage:
//   Input: drive value_i and pulse start while busy is low; the item is
//   accepted at that edge and busy rises on the next cycle.
//   Output: one character per result_valid_o strobe in result_o, most
//   significant first, with '-' first for a negative value; is_last marks
//   the final character. Results cannot be held off and must be taken.
// Sequence:
//   After acceptance the cell row runs the double-dabble pass, one
//   magnitude bit per cycle, then an optional sign step that emits '-',
//   then shifts the digits out of the top cell (leading zeros are dropped
//   silently). busy stays high until the final character's strobe is
//   issued. A new item can be taken on the edge that ends the last
//   character's strobe; no new item is taken while one is in flight, so
//   the item rate is set by the bit-serial dabble pass and the digit
//   shift-out through the row.
// Reset: asynchronous, active low; returns the block to idle, no result
//   pending, all digit cells zero.
`default_nettype none

module int128_to_signed_decimal (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  input  i2d_pkg::in_item_t     value_i,
  output logic                  busy,
  output logic                  result_valid_o,
  output i2d_pkg::out_item_t    result_o
);

  localparam int EB = i2d_pkg::EFF_BITS;
  localparam int DS = i2d_pkg::DIGIT_SLOTS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SIGN,
    S_EMIT
  } state_e;

  state_e                          state_q;
  logic [EB-1:0]                   mag_q;
  logic                            neg_q;
  logic [i2d_pkg::BIT_CNT_W-1:0]   bit_cnt_q;
  logic [i2d_pkg::DIG_CNT_W-1:0]   dig_cnt_q;
  logic                            started_q;
  logic                            result_valid_q;
  i2d_pkg::out_item_t              result_q;

  logic [127:0]         word;
  logic [EB-1:0]        word_eff;
  logic                 word_neg;
  logic [EB-1:0]        mag_load;
  logic                 accept;
  logic                 emit_now;
  i2d_pkg::cell_ctrl_t  ctrl;
  logic [3:0]           digit_w [DS];
  logic                 carry_w [DS];
  logic [3:0]           top_digit;

  assign word     = {value_i.value_high, value_i.value_low};
  assign word_eff = word[EB-1:0];
  assign word_neg = word_eff[EB-1];
  assign mag_load = word_neg ? (~word_eff) + {{(EB-1){1'b0}}, 1'b1} : word_eff;
  assign accept   = start && (state_q == S_IDLE);
  assign busy     = (state_q != S_IDLE);

  assign top_digit = digit_w[DS-1];
  assign emit_now  = started_q || (top_digit != 4'd0) ||
                     (dig_cnt_q == i2d_pkg::DIG_CNT_W'(1));

  assign ctrl.clear  = accept;
  assign ctrl.dabble = (state_q == S_CONV);
  assign ctrl.shift  = (state_q == S_EMIT);

  for (genvar k = 0; k < DS; k++) begin : g_cell
    logic       cin;
    logic [3:0] din;
    if (k == 0) begin : g_first
      assign cin = mag_q[EB-1];
      assign din = 4'd0;
    end else begin : g_rest
      assign cin = carry_w[k-1];
      assign din = digit_w[k-1];
    end
    i2d_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .carry_i (cin),
      .digit_i (din),
      .carry_o (carry_w[k]),
      .digit_o (digit_w[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      mag_q          <= '0;
      neg_q          <= 1'b0;
      bit_cnt_q      <= '0;
      dig_cnt_q      <= '0;
      started_q      <= 1'b0;
      result_valid_q <= 1'b0;
      result_q       <= '0;
    end else begin
      result_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            state_q   <= S_CONV;
            mag_q     <= mag_load;
            neg_q     <= word_neg;
            bit_cnt_q <= i2d_pkg::BIT_CNT_W'(EB - 1);
          end
        end
        S_CONV: begin
          mag_q     <= mag_q << 1;
          bit_cnt_q <= bit_cnt_q - i2d_pkg::BIT_CNT_W'(1);
          if (bit_cnt_q == '0) begin
            state_q   <= neg_q ? S_SIGN : S_EMIT;
            dig_cnt_q <= i2d_pkg::DIG_CNT_W'(DS);
            started_q <= 1'b0;
          end
        end
        S_SIGN: begin
          result_valid_q     <= 1'b1;
          result_q.text_char <= i2d_pkg::CHAR_MINUS;
          result_q.is_last   <= 1'b0;
          state_q            <= S_EMIT;
        end
        S_EMIT: begin
          dig_cnt_q <= dig_cnt_q - i2d_pkg::DIG_CNT_W'(1);
          if (emit_now) begin
            started_q          <= 1'b1;
            result_valid_q     <= 1'b1;
            result_q.text_char <= i2d_pkg::CHAR_ZERO + {2'b00, top_digit};
            result_q.is_last   <= (dig_cnt_q == i2d_pkg::DIG_CNT_W'(1));
          end
          if (dig_cnt_q == i2d_pkg::DIG_CNT_W'(1)) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CONV) |-> !carry_w[DS-1])
    else $error("carry out of top digit cell");

  a_quiet_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CONV) |-> !result_valid_q)
    else $error("result strobe during conversion");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_q && (result_q.text_char == i2d_pkg::CHAR_MINUS)) |-> !result_q.is_last)
    else $error("minus sign marked as last character");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted item");

endmodule

`default_nettype wire

// File: dv/int128_to_signed_decimal_tb.sv
// Testbench for int128_to_signed_decimal: directed and random 128-bit values, each
// character result checked against the expected signed decimal text (table or predictor).
// Depends on i2d_pkg and the int128_to_signed_decimal RTL.
module int128_to_signed_decimal_tb;

  localparam int RANDOM_ITEMS   = 400;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int NUM_ROWS       = 20;

  typedef struct {
    logic [127:0] word;
    string        text;
  } text_row_t;

  logic               clk_i   = 1'b0;
  logic               rst_ni  = 1'b0;
  logic               start   = 1'b0;
  i2d_pkg::in_item_t  value_i = '0;
  logic               busy;
  logic               result_valid_o;
  i2d_pkg::out_item_t result_o;

  i2d_pkg::out_item_t pending_chars[$];
  text_row_t          rows [NUM_ROWS];
  int        mismatches     = 0;
  int        chars_seen     = 0;
  int        values_sent    = 0;
  int        negatives_sent = 0;
  int        idle_cycles    = 0;
  int        burst_left     = 0;

  int128_to_signed_decimal uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .value_i        (value_i),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic string decimal_text(logic [127:0] word);
    logic [127:0] mag;
    string        digits;
    digits = "";
    mag = word[127] ? ~word + 128'd1 : word;
    do begin
      digits = {$sformatf("%0d", int'(mag % 128'd10)), digits};
      mag = mag / 128'd10;
    end while (mag != 0);
    return word[127] ? {"-", digits} : digits;
  endfunction

  function automatic logic [127:0] power_of_ten(int k);
    logic [127:0] p;
    p = 128'd1;
    repeat (k) p = p * 128'd10;
    return p;
  endfunction

  // mix of full-width, small, power-of-two, power-of-ten and right-shifted values, randomly negated
  function automatic logic [127:0] random_word();
    logic [127:0] w;
    w = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(0, 4))
      0: ;
      1: w = 128'($urandom_range(0, 999));
      2: w = (128'd1 << $urandom_range(0, 127)) - 128'($urandom_range(0, 1));
      3: w = power_of_ten($urandom_range(0, 38)) - 128'($urandom_range(0, 1));
      default: w = w >> $urandom_range(1, 126);
    endcase
    if ($urandom_range(0, 1) == 1) w = -w;
    return w;
  endfunction

  task automatic send_value(logic [127:0] word, string text);
    string              chars;
    i2d_pkg::out_item_t item;
    value_i <= word;
    start   <= 1'b1;
    do @(posedge clk_i); while (busy);
    chars = (text.len() != 0) ? text : decimal_text(word);
    for (int i = 0; i < chars.len(); i++) begin
      item.text_char = 6'(chars[i]);
      item.is_last   = (i == chars.len() - 1);
      pending_chars  = {pending_chars, item};
    end
    values_sent++;
    if (word[127]) negatives_sent++;
  endtask

  task automatic pause_sender(int cycles, bit drain);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
    if (drain) begin
      do @(posedge clk_i); while (pending_chars.size() != 0);
    end
  endtask

  always @(posedge clk_i) begin : check_chars
    i2d_pkg::out_item_t want;
    if (rst_ni && result_valid_o) begin
      chars_seen++;
      if (pending_chars.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item: actual char %0d last %0b",
                 $time, result_o.text_char, result_o.is_last);
      end else begin
        want = pending_chars.pop_front();
        if (result_o.text_char !== want.text_char) begin
          mismatches++;
          $display("%0t: text_char mismatch: expected %0d, actual %0d",
                   $time, want.text_char, result_o.text_char);
        end
        if (result_o.is_last !== want.is_last) begin
          mismatches++;
          $display("%0t: is_last mismatch: expected %0b, actual %0b",
                   $time, want.is_last, result_o.is_last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d chars outstanding", $time, pending_chars.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rows = '{
      '{128'd0, "0"},
      '{128'd1, "1"},
      '{{128{1'b1}}, "-1"},
      '{128'd9, "9"},
      '{128'd10, "10"},
      '{-128'd10, "-10"},
      '{{1'b0, {127{1'b1}}}, "170141183460469231731687303715884105727"},
      '{{1'b1, 127'd0}, "-170141183460469231731687303715884105728"},
      '{{64'd0, {64{1'b1}}}, "18446744073709551615"},
      '{{64'd1, 64'd0}, "18446744073709551616"},
      '{{{64{1'b1}}, 64'd0}, "-18446744073709551616"},
      '{{64'd0, 64'h8000_0000_0000_0000}, "9223372036854775808"},
      '{{{64{1'b1}}, 64'h8000_0000_0000_0000}, "-9223372036854775808"},
      '{128'd99999999999999999999999999999999999999,
        "99999999999999999999999999999999999999"},
      '{128'd100000000000000000000000000000000000000,
        "100000000000000000000000000000000000000"},
      '{-128'd100000000000000000000000000000000000000,
        "-100000000000000000000000000000000000000"},
      '{{32{4'ha}}, ""},
      '{{32{4'h5}}, ""},
      '{128'h0123456789abcdef_fedcba9876543210, ""},
      '{128'h8000_0000_0000_0000_0000_0000_0000_0001, ""}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_value(rows[i].word, rows[i].text);
    pause_sender(0, 1);

    burst_left = $urandom_range(1, 12);
    repeat (RANDOM_ITEMS) begin
      send_value(random_word(), "");
      if (burst_left == 0) begin
        pause_sender($urandom_range(1, 190), 0);
        burst_left = $urandom_range(0, 12);
      end else if ($urandom_range(0, 49) == 0) begin
        pause_sender(0, 1);
      end else begin
        burst_left--;
      end
    end

    pause_sender(0, 1);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Converted %0d values (%0d negative, %0d directed) into %0d characters.",
             values_sent, negatives_sent, NUM_ROWS, chars_seen);
    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d chars never seen", mismatches, pending_chars.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/i2d_pkg.sv
rtl/i2d_cell.sv
rtl/int128_to_signed_decimal.sv
dv/int128_to_signed_decimal_tb.sv
